// ===== sv/assert_macros.svh =====
// Shared assertion macros for the calibration block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk while rst is low.
`define ASSERT_PROP(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Checks that a condition never holds while rst is low.
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== sv/tacsf_pkg.sv =====
package tacsf_pkg;

  localparam int CfgIndexW  = 4;
  localparam int CfgDataW   = 32;
  localparam int QueueDepth = 2;
  localparam int DivSteps   = 32;

  localparam logic [31:0] ResetCoefXx   = 32'sd402336;
  localparam logic [31:0] ResetCoefXy   = -32'sd7584;
  localparam logic [31:0] ResetOffsetX  = -32'sd1517124408;
  localparam logic [31:0] ResetCoefYx   = -32'sd5376;
  localparam logic [31:0] ResetCoefYy   = 32'sd536960;
  localparam logic [31:0] ResetOffsetY  = -32'sd2098038304;
  localparam logic [31:0] ResetDivisor  = -32'sd5859309;
  localparam logic [11:0] ResetTolerance = 12'd1;

  localparam logic [31:0] MaxPositive = 32'h7fff_ffff;

  typedef enum logic [CfgIndexW-1:0] {
    REG_COEF_XX   = 4'd0,
    REG_COEF_XY   = 4'd1,
    REG_OFFSET_X  = 4'd2,
    REG_COEF_YX   = 4'd3,
    REG_COEF_YY   = 4'd4,
    REG_OFFSET_Y  = 4'd5,
    REG_DIVISOR   = 4'd6,
    REG_TOLERANCE = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] coef_xx;
    logic [31:0] coef_xy;
    logic [31:0] offset_x;
    logic [31:0] coef_yx;
    logic [31:0] coef_yy;
    logic [31:0] offset_y;
    logic [31:0] divisor;
    logic [11:0] tolerance;
  } cfg_t;

  typedef struct packed {
    logic [11:0] raw_x;
    logic [11:0] raw_y;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic [1:0]         match_count;
    logic               stable;
    logic               divide_error;
  } result_t;

  // Affine numerators handed from the front end to the back end.
  typedef struct packed {
    logic [31:0] num_x;
    logic [31:0] num_y;
  } num_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_FILTER
  } back_state_t;

endpackage

// ===== sv/tacsf_div.sv =====
`include "assert_macros.svh"

module tacsf_div import tacsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic [31:0] quotient
);

  localparam int StepW = $clog2(DivSteps);
  localparam logic [StepW-1:0] StepLast = StepW'(DivSteps - 1);

  logic [31:0]      rem;
  logic [31:0]      quo;
  logic [31:0]      dvs;
  logic             neg;
  logic [StepW-1:0] cnt;
  logic [32:0]      shifted;
  logic [32:0]      diff;

  assign shifted = {rem, quo[31]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == StepLast) begin
        busy <= 1'b0;
      end
    end
  end

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num[31] ? -num : num;
      dvs <= den[31] ? -den : den;
      rem <= '0;
      neg <= num[31] ^ den[31];
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  // Only the most negative value divided by minus one can overflow.
  always_comb begin
    if (neg) begin
      quotient = -quo;
    end else if (quo[31]) begin
      quotient = MaxPositive;
    end else begin
      quotient = quo;
    end
  end

  `ASSERT_PROP(a_start_sets_busy, clk, rst, start |=> busy)
  `ASSERT_PROP(a_last_step_ends, clk, rst, (busy && !start && cnt == StepLast) |=> !busy)

endmodule

// ===== sv/tacsf_queue.sv =====
`include "assert_macros.svh"

module tacsf_queue import tacsf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  num_t wdata,
  output logic full,
  input  logic rd,
  output num_t rdata,
  output logic empty
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QueueDepth - 1);

  num_t            mem [QueueDepth];
  logic [PtrW-1:0] wptr;
  logic [PtrW-1:0] rptr;
  logic [CntW-1:0] cnt;
  logic            do_wr;
  logic            do_rd;

  assign full  = (cnt == CntW'(QueueDepth));
  assign empty = (cnt == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PtrLast) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PtrLast) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  // The front end must hold its entry while the queue is full.
  `ASSERT_NEVER(a_no_overflow, clk, rst, wr && full)

endmodule

// ===== sv/tacsf_front.sv =====
module tacsf_front import tacsf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    push,
  input  sample_t sample,
  output logic    full,
  output logic    q_wr,
  output num_t    q_data,
  input  logic    q_full
);

  logic        held;
  logic        accept;
  logic [31:0] p_xx;
  logic [31:0] p_xy;
  logic [31:0] p_yx;
  logic [31:0] p_yy;

  assign q_wr   = held && !q_full;
  assign full   = held && q_full;
  assign accept = push && !full;

  assign q_data.num_x = p_xx + p_xy + cfg.offset_x;
  assign q_data.num_y = p_yx + p_yy + cfg.offset_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (q_wr) begin
      held <= 1'b0;
    end
  end

  // Products wrap to 32 bits, so signed and unsigned multiplies agree.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_xx <= cfg.coef_xx * 32'(sample.raw_x);
      p_xy <= cfg.coef_xy * 32'(sample.raw_y);
      p_yx <= cfg.coef_yx * 32'(sample.raw_x);
      p_yy <= cfg.coef_yy * 32'(sample.raw_y);
    end
  end

endmodule

// ===== sv/tacsf_back.sv =====
`include "assert_macros.svh"

module tacsf_back import tacsf_pkg::*; #(
  parameter int HISTORY_DEPTH = 3
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    q_empty,
  input  num_t    q_data,
  output logic    q_rd,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  localparam int CountW = $clog2(HISTORY_DEPTH + 1);

  back_state_t       state;
  back_state_t       state_next;
  logic              div_start;
  logic              busy_x;
  logic              busy_y;
  logic [31:0]       quo_x;
  logic [31:0]       quo_y;
  logic              err;
  logic              out_valid;
  logic              out_load;
  logic [31:0]       sx;
  logic [31:0]       sy;
  logic [CountW-1:0] count;
  logic [31:0]       hist_x [HISTORY_DEPTH];
  logic [31:0]       hist_y [HISTORY_DEPTH];

  tacsf_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (q_data.num_x),
    .den      (cfg.divisor),
    .busy     (busy_x),
    .quotient (quo_x)
  );

  tacsf_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (q_data.num_y),
    .den      (cfg.divisor),
    .busy     (busy_y),
    .quotient (quo_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_rd       = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          q_rd       = 1'b1;
          div_start  = (cfg.divisor != '0);
          state_next = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (err || (!busy_x && !busy_y)) begin
          state_next = BK_FILTER;
        end
      end
      BK_FILTER: begin
        if (!out_valid || pop) begin
          out_load   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      err <= (cfg.divisor == '0);
    end
  end

  assign sx = err ? '0 : quo_x;
  assign sy = err ? '0 : quo_y;

  // A history point matches when the new point is at or ahead of it by no
  // more than the tolerance on both axes, using exact 33-bit differences.
  always_comb begin
    logic [32:0] dx;
    logic [32:0] dy;
    count = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      dx = {sx[31], sx} - {hist_x[i][31], hist_x[i]};
      dy = {sy[31], sy} - {hist_y[i][31], hist_y[i]};
      if (!dx[32] && dx <= {21'd0, cfg.tolerance} &&
          !dy[32] && dy <= {21'd0, cfg.tolerance}) begin
        count = count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_x[i] <= '0;
        hist_y[i] <= '0;
      end
    end else if (out_load) begin
      for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
        hist_x[i] <= hist_x[i-1];
        hist_y[i] <= hist_y[i-1];
      end
      hist_x[0] <= sx;
      hist_y[0] <= sy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.screen_x     <= sx;
      result.screen_y     <= sy;
      result.match_count  <= (32'(count) > 32'd3) ? 2'd3 : 2'(count);
      result.stable       <= (32'(count) >= 32'(HISTORY_DEPTH));
      result.divide_error <= err;
    end
  end

  assign empty = !out_valid;

  `ASSERT_NEVER(a_start_while_busy, clk, rst, div_start && (busy_x || busy_y))
  `ASSERT_PROP(a_load_gives_result, clk, rst, out_load |=> out_valid)
  `ASSERT_PROP(a_filter_after_divide, clk, rst,
    (state == BK_FILTER) |-> (err || (!busy_x && !busy_y)))

endmodule

// ===== sv/touch_affine_calibrate_stability_filter_unit.sv =====
// Maps raw 12-bit touch samples to screen coordinates with an affine
// transform, (a*x + b*y + c) / divisor per axis, and flags whether the point
// has settled against the last HISTORY_DEPTH calibrated points. Samples are
// pushed into a front end that registers the products and forms the
// numerators, wait in a two-entry queue, and are divided in the back end by
// two radix-2 dividers that run side by side, one quotient bit per cycle.
// The back end takes one item at a time: it reads the queue and starts the
// dividers, waits while they step through the quotient bits until both are
// done, then filters against the history and loads the result once the
// output is free; the front end and queue take new samples meanwhile. With
// a zero divisor the dividers are skipped and a zero divide error results.
// Configuration may be written only while no sample is in flight.
module touch_affine_calibrate_stability_filter_unit import tacsf_pkg::*; #(
  parameter int HISTORY_DEPTH = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  sample_t              sample,
  output logic                 empty,
  input  logic                 pop,
  output result_t              result,
  input  logic                 cfg_write,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  cfg_t cfg;
  logic q_wr;
  logic q_full;
  logic q_rd;
  logic q_empty;
  num_t q_wdata;
  num_t q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coef_xx   <= ResetCoefXx;
      cfg.coef_xy   <= ResetCoefXy;
      cfg.offset_x  <= ResetOffsetX;
      cfg.coef_yx   <= ResetCoefYx;
      cfg.coef_yy   <= ResetCoefYy;
      cfg.offset_y  <= ResetOffsetY;
      cfg.divisor   <= ResetDivisor;
      cfg.tolerance <= ResetTolerance;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COEF_XX:   cfg.coef_xx   <= cfg_data;
        REG_COEF_XY:   cfg.coef_xy   <= cfg_data;
        REG_OFFSET_X:  cfg.offset_x  <= cfg_data;
        REG_COEF_YX:   cfg.coef_yx   <= cfg_data;
        REG_COEF_YY:   cfg.coef_yy   <= cfg_data;
        REG_OFFSET_Y:  cfg.offset_y  <= cfg_data;
        REG_DIVISOR:   cfg.divisor   <= cfg_data;
        REG_TOLERANCE: cfg.tolerance <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  tacsf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .push   (push),
    .sample (sample),
    .full   (full),
    .q_wr   (q_wr),
    .q_data (q_wdata),
    .q_full (q_full)
  );

  tacsf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  tacsf_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_rd    (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tacsf_pkg::*;

  localparam int HistoryDepth     = 3;
  localparam int MaxIdle          = 10;
  localparam int HoldOffCycles    = 400;
  localparam int SettleCycles     = 60;
  localparam int RandomPerPhase   = 130;
  localparam int RandomPhases     = 10;
  localparam int CycleLimit       = 400000;
  localparam int FirstUnusedIndex = int'(REG_TOLERANCE) + 1;
  localparam int LastIndex        = (1 << CfgIndexW) - 1;

  // Tracks the calibration settings and point history, and holds the calibrated
  // points that the block still owes.
  class calibration_scoreboard;
    cfg_t        settings;
    logic [31:0] trail_x[HistoryDepth];
    logic [31:0] trail_y[HistoryDepth];
    result_t     expected_points[$];
    int          mismatches;
    int          samples_seen;
    int          stable_seen;
    int          div_errors_seen;

    function new();
      settings = '{ResetCoefXx, ResetCoefXy, ResetOffsetX, ResetCoefYx, ResetCoefYy,
                   ResetOffsetY, ResetDivisor, ResetTolerance};
      foreach (trail_x[i]) begin
        trail_x[i] = '0;
        trail_y[i] = '0;
      end
      mismatches      = 0;
      samples_seen    = 0;
      stable_seen     = 0;
      div_errors_seen = 0;
    endfunction

    function void set_register(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        REG_COEF_XX:   settings.coef_xx   = value;
        REG_COEF_XY:   settings.coef_xy   = value;
        REG_OFFSET_X:  settings.offset_x  = value;
        REG_COEF_YX:   settings.coef_yx   = value;
        REG_COEF_YY:   settings.coef_yy   = value;
        REG_OFFSET_Y:  settings.offset_y  = value;
        REG_DIVISOR:   settings.divisor   = value;
        REG_TOLERANCE: settings.tolerance = value[11:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] divide_toward_zero(logic [31:0] num, logic [31:0] den);
      logic [31:0] mag_num;
      logic [31:0] mag_den;
      logic [31:0] quot;
      mag_num = num[31] ? -num : num;
      mag_den = den[31] ? -den : den;
      quot = mag_num / mag_den;
      if (num[31] != den[31]) return -quot;
      // Only the most negative numerator over -1 lands here.
      if (quot > MaxPositive) return MaxPositive;
      return quot;
    endfunction

    // The difference is formed at 33 bits so that it never wraps.
    function bit follows(logic [31:0] now, logic [31:0] old);
      logic signed [32:0] diff;
      diff = $signed({now[31], now}) - $signed({old[31], old});
      return diff >= 0 && diff <= $signed({21'b0, settings.tolerance});
    endfunction

    function void note_sample(sample_t s);
      logic [31:0] num_x;
      logic [31:0] num_y;
      int unsigned hits;
      result_t     point;
      num_x = settings.coef_xx * 32'(s.raw_x) + settings.coef_xy * 32'(s.raw_y)
              + settings.offset_x;
      num_y = settings.coef_yx * 32'(s.raw_x) + settings.coef_yy * 32'(s.raw_y)
              + settings.offset_y;
      point = '0;
      if (settings.divisor == '0) begin
        point.divide_error = 1'b1;
      end else begin
        point.screen_x = divide_toward_zero(num_x, settings.divisor);
        point.screen_y = divide_toward_zero(num_y, settings.divisor);
      end
      hits = 0;
      for (int i = 0; i < HistoryDepth; i++) begin
        if (follows(point.screen_x, trail_x[i]) && follows(point.screen_y, trail_y[i]))
          hits++;
      end
      point.match_count = (hits > 3) ? 2'd3 : 2'(hits);
      point.stable      = (hits >= HistoryDepth);
      for (int i = HistoryDepth - 1; i > 0; i--) begin
        trail_x[i] = trail_x[i-1];
        trail_y[i] = trail_y[i-1];
      end
      trail_x[0] = point.screen_x;
      trail_y[0] = point.screen_y;
      expected_points.push_back(point);
      samples_seen++;
    endfunction

    function int waiting();
      return expected_points.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_point(result_t got);
      result_t want;
      if (expected_points.size() == 0) begin
        report_mismatch("calibrated point with no sample outstanding");
        return;
      end
      want = expected_points.pop_front();
      if (got.screen_x !== want.screen_x)
        report_mismatch($sformatf("screen_x got %0d want %0d", got.screen_x, want.screen_x));
      if (got.screen_y !== want.screen_y)
        report_mismatch($sformatf("screen_y got %0d want %0d", got.screen_y, want.screen_y));
      if (got.match_count !== want.match_count)
        report_mismatch($sformatf("match_count got %0d want %0d",
                                  got.match_count, want.match_count));
      if (got.stable !== want.stable)
        report_mismatch($sformatf("stable got %b want %b", got.stable, want.stable));
      if (got.divide_error !== want.divide_error)
        report_mismatch($sformatf("divide_error got %b want %b",
                                  got.divide_error, want.divide_error));
      if (want.stable) stable_seen++;
      if (want.divide_error) div_errors_seen++;
    endtask
  endclass

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 push      = 1'b0;
  logic                 full;
  sample_t              sample    = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  result_t              result;
  logic                 cfg_write = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0]  cfg_data  = '0;

  calibration_scoreboard sb;
  bit no_idle        = 1'b0;
  bit hold_request   = 1'b0;
  int configs_loaded = 0;
  int cycle_count    = 0;

  touch_affine_calibrate_stability_filter_unit #(.HISTORY_DEPTH(HistoryDepth)) DUT (
    .clk,
    .rst,
    .push,
    .full,
    .sample,
    .empty,
    .pop,
    .result,
    .cfg_write,
    .cfg_index,
    .cfg_data
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_register(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  task automatic load_settings(cfg_t c);
    write_register(REG_COEF_XX, c.coef_xx);
    write_register(REG_COEF_XY, c.coef_xy);
    write_register(REG_OFFSET_X, c.offset_x);
    write_register(REG_COEF_YX, c.coef_yx);
    write_register(REG_COEF_YY, c.coef_yy);
    write_register(REG_OFFSET_Y, c.offset_y);
    write_register(REG_DIVISOR, c.divisor);
    write_register(REG_TOLERANCE, {20'($urandom), c.tolerance});
    // Writes to indexes past the last register must leave everything alone.
    write_register(CfgIndexW'($urandom_range(LastIndex, FirstUnusedIndex)), $urandom);
    cfg_write <= 1'b0;
    configs_loaded++;
  endtask

  task automatic send_sample(logic [11:0] x, logic [11:0] y);
    int gap;
    gap = no_idle ? 0 : $urandom_range(MaxIdle);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push   <= 1'b1;
    sample <= '{raw_x: x, raw_y: y};
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_sample(sample);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (sb.waiting() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return MaxPositive;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      4, 5: return {{16{w[15]}}, w[15:0]};
      default: return w;
    endcase
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.coef_xx   = pick_word();
    c.coef_xy   = pick_word();
    c.offset_x  = pick_word();
    c.coef_yx   = pick_word();
    c.coef_yy   = pick_word();
    c.offset_y  = pick_word();
    c.divisor   = ($urandom_range(7) == 0) ? 32'h0 : pick_word();
    c.tolerance = $urandom_range(1) ? 12'($urandom_range(4)) : 12'($urandom);
    return c;
  endfunction

  // Mostly short bursts of repeated or slowly creeping touches, which is what
  // lets the history fill with matching points; the rest is scattered noise.
  task automatic run_random_phase(int count);
    int          sent;
    int          run_len;
    logic [11:0] x;
    logic [11:0] y;
    sent = 0;
    while (sent < count) begin
      x = 12'($urandom);
      y = 12'($urandom);
      if ($urandom_range(9) < 7) begin
        run_len = $urandom_range(8, 3);
        for (int k = 0; k < run_len && sent < count; k++) begin
          send_sample(x, y);
          sent++;
          if ($urandom_range(2) == 0) begin
            x = x + 12'($urandom_range(2));
            y = y + 12'($urandom_range(2));
          end
        end
      end else begin
        send_sample(x, y);
        sent++;
      end
    end
  endtask

  initial begin : drain_results
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        pop <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(MaxIdle);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      sb.check_point(result);
    end
  end

  initial begin : drive_samples
    cfg_t plan;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Corners of the raw range, then a repeated interior point, under the settings left by reset.
    send_sample(12'd0, 12'd0);
    send_sample(12'd4095, 12'd4095);
    send_sample(12'd4095, 12'd0);
    send_sample(12'd0, 12'd4095);
    send_sample(12'd1365, 12'd2730);
    send_sample(12'd1365, 12'd2730);
    send_sample(12'd1365, 12'd2730);
    wait_idle();

    // Pass-through mapping with zero tolerance: only exact repeats match.
    plan = '{coef_xx: 32'd1, coef_xy: 32'd0, offset_x: 32'd0, coef_yx: 32'd0,
             coef_yy: 32'd1, offset_y: 32'd0, divisor: 32'd1, tolerance: 12'd0};
    load_settings(plan);
    send_sample(12'd100, 12'd100);
    send_sample(12'd100, 12'd100);
    send_sample(12'd100, 12'd100);
    send_sample(12'd101, 12'd101);
    wait_idle();

    // Most negative numerator over -1 saturates; widest tolerance.
    plan = '{coef_xx: 32'h0, coef_xy: 32'h0, offset_x: 32'h8000_0000,
             coef_yx: MaxPositive, coef_yy: 32'h8000_0000, offset_y: MaxPositive,
             divisor: 32'hffff_ffff, tolerance: 12'hfff};
    load_settings(plan);
    send_sample(12'd0, 12'd0);
    send_sample(12'd4095, 12'd4095);
    send_sample(12'd1, 12'd1);
    wait_idle();

    // A zero divisor flags an error and feeds the origin into the history.
    plan.divisor   = 32'h0;
    plan.tolerance = 12'd0;
    load_settings(plan);
    send_sample(12'd5, 12'd5);
    send_sample(12'd4095, 12'd0);
    send_sample(12'd0, 12'd4095);
    wait_idle();

    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: begin
          plan = '{coef_xx: 32'd1, coef_xy: 32'd0, offset_x: 32'd0, coef_yx: 32'd0,
                   coef_yy: 32'd1, offset_y: 32'd0, divisor: 32'd1,
                   tolerance: 12'($urandom_range(3))};
        end
        1: begin
          plan = '{ResetCoefXx, ResetCoefXy, ResetOffsetX, ResetCoefYx, ResetCoefYy,
                   ResetOffsetY, ResetDivisor, ResetTolerance};
        end
        3: begin
          plan = random_settings();
          plan.divisor = 32'h0;
        end
        default: plan = random_settings();
      endcase
      no_idle = (phase == 5 || phase == 6 || phase == 8);
      // The receiver stops for a long stretch so that the block backs up.
      if (phase == 2 || phase == 6) hold_request = 1'b1;
      load_settings(plan);
      run_random_phase(RandomPerPhase);
      wait_idle();
    end

    $display("Covered %0d touch samples across %0d calibration settings.",
             sb.samples_seen, configs_loaded);
    $display("Saw %0d stable points and %0d divide errors.",
             sb.stable_seen, sb.div_errors_seen);
    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/tacsf_pkg.sv
sv/tacsf_div.sv
sv/tacsf_queue.sv
sv/tacsf_front.sv
sv/tacsf_back.sv
sv/touch_affine_calibrate_stability_filter_unit.sv
bench/testbench.sv
